// ----- rtl/lts_pkg.sv -----
// ----------------------------------------------------------------------------
// lts_pkg: shared types and constants of the translation store
// Field widths, request codes, controller states and the handshake structs
// that pass between the controller and the scan unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lts_pkg;

    localparam int VA_PORT_W   = 48;
    localparam int PHYS_W      = 52;
    localparam int PLOG_W      = 5;
    localparam int ATTR_W      = 8;
    localparam int AGE_W       = 32;
    localparam int TDATA_W     = 120;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TUSER_W = 2;

    localparam logic [PLOG_W-1:0] PL_MIN = 5'd12;
    localparam logic [PLOG_W-1:0] PL_MAX = 5'd30;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_FILL   = 2'd1,
        REQ_INVAL  = 2'd2,
        REQ_FLUSH  = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } state_t;

    // controller -> scan unit
    typedef struct packed {
        logic start;   // clear trackers for a new request
        logic cmp;     // read data of one entry is present this cycle
    } scan_ctl_t;

    // scan unit -> controller
    typedef struct packed {
        logic match_found;
        logic free_found;
    } scan_stat_t;

endpackage

`default_nettype wire

// ----- rtl/lts_ram.sv -----
// ----------------------------------------------------------------------------
// lts_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lts_scan.sv -----
// ----------------------------------------------------------------------------
// lts_scan: per-entry compare and tracking unit
// Sees one stored entry per cycle and keeps the lowest matching index, the
// lowest free index and the lowest index holding the smallest age stamp.
// ----------------------------------------------------------------------------
`default_nettype none

module lts_scan #(
    parameter int ENTRIES = 16,
    parameter int VA_W    = 48
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire lts_pkg::scan_ctl_t                    ctl,
    input  wire logic [$clog2(ENTRIES)-1:0]            rd_idx,
    input  wire logic                                  ent_valid,
    input  wire logic [VA_W+lts_pkg::PHYS_W+lts_pkg::PLOG_W+lts_pkg::ATTR_W-1:0] ent_word,
    input  wire logic [lts_pkg::AGE_W-1:0]             ent_age,
    input  wire logic [VA_W-1:0]                       req_va,
    output lts_pkg::scan_stat_t                        stat,
    output logic [$clog2(ENTRIES)-1:0]                 match_idx,
    output logic [$clog2(ENTRIES)-1:0]                 free_idx,
    output logic [$clog2(ENTRIES)-1:0]                 old_idx,
    output logic [VA_W+lts_pkg::PHYS_W+lts_pkg::PLOG_W+lts_pkg::ATTR_W-1:0] hit_word
);
    import lts_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int WORD_W = VA_W + PHYS_W + PLOG_W + ATTR_W;

    logic                match_found_reg, free_found_reg, old_seen_reg;
    logic [IDX_W-1:0]    match_idx_reg, free_idx_reg, old_idx_reg;
    logic [AGE_W-1:0]    old_age_reg;
    logic [WORD_W-1:0]   hit_word_reg;

    logic [VA_W-1:0]     ent_va;
    logic [PLOG_W-1:0]   ent_plog;
    logic [VA_W-1:0]     page_mask;
    logic                is_match;
    logic                is_older;

    assign ent_va    = ent_word[VA_W-1:0];
    assign ent_plog  = ent_word[VA_W+PHYS_W +: PLOG_W];
    assign page_mask = {VA_W{1'b1}} << ent_plog;
    assign is_match  = ent_valid && (((req_va ^ ent_va) & page_mask) == '0);
    assign is_older  = ent_valid && (!old_seen_reg || (ent_age < old_age_reg));

    // control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            old_seen_reg    <= 1'b0;
        end else if (ctl.start) begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            old_seen_reg    <= 1'b0;
        end else if (ctl.cmp) begin
            if (is_match) begin
                match_found_reg <= 1'b1;
            end
            if (!ent_valid) begin
                free_found_reg <= 1'b1;
            end
            if (is_older) begin
                old_seen_reg <= 1'b1;
            end
        end
    end

    // tracked indexes and captured entry; keep only the first hit and free slot
    always_ff @(posedge aclk) begin
        if (ctl.cmp && !ctl.start) begin
            if (is_match && !match_found_reg) begin
                match_idx_reg <= rd_idx;
                hit_word_reg  <= ent_word;
            end
            if (!ent_valid && !free_found_reg) begin
                free_idx_reg <= rd_idx;
            end
            if (is_older) begin
                old_idx_reg <= rd_idx;
                old_age_reg <= ent_age;
            end
        end
    end

    assign stat.match_found = match_found_reg;
    assign stat.free_found  = free_found_reg;
    assign match_idx        = match_idx_reg;
    assign free_idx         = free_idx_reg;
    assign old_idx          = old_idx_reg;
    assign hit_word         = hit_word_reg;

endmodule

`default_nettype wire

// ----- rtl/lru_translation_store.sv -----
// ----------------------------------------------------------------------------
// lru_translation_store: fully associative translation store with LRU fill
// Lookup, fill, invalidate and flush on a table of ENTRIES entries kept in
// two synchronous RAMs (entry contents and age stamps).
// ----------------------------------------------------------------------------
// Usage:
//   Send one request per s_ handshake; s_tuser carries the request type and
//   the refresh flag, s_tdata the address and fill contents. Every request
//   returns exactly one result on the m_ channel; m_tuser carries hit and
//   evicted, m_tdata the returned entry (all zero on a miss or a flush).
//   Timing: a lookup, fill or invalidate reads every entry once, one entry
//   per cycle through the RAM read port, then passes a drain and a decide
//   step before its result is presented; a flush needs no scan and goes
//   straight to the decide step. The block takes one request at a time:
//   s_tready rises again as the result is loaded into the output register.
//   The output register holds its result while m_tready is low; the next
//   request may be taken and scanned meanwhile and waits in its final step
//   until the output register frees up.
//   Reset clears all valid bits and the age counter at once; RAM contents
//   need no clearing since only valid entries are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_translation_store #(
    parameter int ENTRIES    = 16,
    parameter int VADDR_BITS = 48
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // request channel
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata: virt_addr[47:0], fill_phys_addr[99:48], fill_page_log[104:100],
    //          fill_attrs[112:105], zero[119:113]
    input  wire logic [lts_pkg::TDATA_W-1:0]        s_tdata,
    // s_tuser: req_type[1:0], refresh_age[2]
    input  wire logic [lts_pkg::IN_TUSER_W-1:0]     s_tuser,
    // result channel
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata: out_virt_addr[47:0], out_phys_addr[99:48], out_page_log[104:100],
    //          out_attrs[112:105], zero[119:113]
    output logic      [lts_pkg::TDATA_W-1:0]        m_tdata,
    // m_tuser: hit[0], evicted[1]
    output logic      [lts_pkg::OUT_TUSER_W-1:0]    m_tuser
);
    import lts_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int VA_W   = (VADDR_BITS < VA_PORT_W) ? VADDR_BITS : VA_PORT_W;
    localparam int WORD_W = VA_W + PHYS_W + PLOG_W + ATTR_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // controller state
    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    cnt_reg;
    logic                rd_valid_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [ENTRIES-1:0]  valid_reg;
    logic [AGE_W-1:0]    age_cnt_reg;

    // latched request
    req_type_t           req_type_reg;
    logic [VA_W-1:0]     va_reg;
    logic                refresh_reg;
    logic [PHYS_W-1:0]   phys_reg;
    logic [PLOG_W-1:0]   plog_reg;
    logic [ATTR_W-1:0]   attrs_reg;

    // output register
    logic                m_tvalid_reg;
    logic                m_hit_reg, m_evict_reg;
    logic [VA_PORT_W-1:0] m_virt_reg;
    logic [PHYS_W-1:0]   m_phys_reg;
    logic [PLOG_W-1:0]   m_plog_reg;
    logic [ATTR_W-1:0]   m_attrs_reg;

    logic                s_accept;
    logic                out_free;
    logic                decide_go;
    logic                rd_en;
    scan_ctl_t           scan_ctl;
    scan_stat_t          scan_stat;
    logic [IDX_W-1:0]    match_idx, free_idx, old_idx, tgt_idx;
    logic [WORD_W-1:0]   hit_word, fill_word, ent_word;
    logic [AGE_W-1:0]    ent_age;
    logic                data_we, age_we;
    logic [PLOG_W-1:0]   in_plog, in_plog_sat;

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = (req_type_t'(s_tuser[1:0]) == REQ_FLUSH) ? ST_DECIDE
                                                                          : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cnt_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- controller outputs ----------------
    always_comb begin
        s_tready     = 1'b0;
        rd_en        = 1'b0;
        decide_go    = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_tready  = 1'b1;
            ST_SCAN:   rd_en     = 1'b1;
            ST_DRAIN:  ;
            ST_DECIDE: decide_go = out_free;
            default:   ;
        endcase
        scan_ctl.start = s_accept;
        scan_ctl.cmp   = rd_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_en;
        end
    end

    // advance the scan address; restart it on every new request
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cnt_reg <= '0;
        end else if (rd_en && cnt_reg != LAST_IDX) begin
            cnt_reg <= cnt_reg + IDX_W'(1);
        end
        rd_idx_reg <= cnt_reg;
    end

    // ---------------- request latch ----------------
    assign in_plog = s_tdata[104:100];

    always_comb begin
        in_plog_sat = in_plog;
        if (in_plog < PL_MIN) begin
            in_plog_sat = PL_MIN;
        end else if (in_plog > PL_MAX) begin
            in_plog_sat = PL_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_type_reg <= req_type_t'(s_tuser[1:0]);
            refresh_reg  <= s_tuser[2];
            va_reg       <= s_tdata[VA_W-1:0];
            phys_reg     <= s_tdata[99:48];
            plog_reg     <= in_plog_sat;
            attrs_reg    <= s_tdata[112:105];
        end
    end

    // ---------------- storage ----------------
    assign fill_word = {attrs_reg, plog_reg, phys_reg, va_reg};

    lts_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_data_ram (
        .aclk  (aclk),
        .we    (data_we),
        .waddr (tgt_idx),
        .wdata (fill_word),
        .re    (rd_en),
        .raddr (cnt_reg),
        .rdata (ent_word)
    );

    lts_ram #(
        .WIDTH (AGE_W),
        .DEPTH (ENTRIES)
    ) u_age_ram (
        .aclk  (aclk),
        .we    (age_we),
        .waddr (tgt_idx),
        .wdata (age_cnt_reg),
        .re    (rd_en),
        .raddr (cnt_reg),
        .rdata (ent_age)
    );

    lts_scan #(
        .ENTRIES (ENTRIES),
        .VA_W    (VA_W)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (scan_ctl),
        .rd_idx    (rd_idx_reg),
        .ent_valid (valid_reg[rd_idx_reg]),
        .ent_word  (ent_word),
        .ent_age   (ent_age),
        .req_va    (va_reg),
        .stat      (scan_stat),
        .match_idx (match_idx),
        .free_idx  (free_idx),
        .old_idx   (old_idx),
        .hit_word  (hit_word)
    );

    // ---------------- decide: write back and build the result ----------------
    // Pick the slot: matching entry first, then lowest free, then oldest stamp.
    always_comb begin
        priority if (scan_stat.match_found) begin
            tgt_idx = match_idx;
        end else if (scan_stat.free_found) begin
            tgt_idx = free_idx;
        end else begin
            tgt_idx = old_idx;
        end
    end

    assign data_we = decide_go && (req_type_reg == REQ_FILL);
    assign age_we  = decide_go && ((req_type_reg == REQ_FILL) ||
                     ((req_type_reg == REQ_LOOKUP) && scan_stat.match_found && refresh_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            age_cnt_reg <= '0;
        end else if (decide_go) begin
            unique case (req_type_reg)
                REQ_LOOKUP: ;
                REQ_FILL:   valid_reg[tgt_idx] <= 1'b1;
                REQ_INVAL: begin
                    if (scan_stat.match_found) begin
                        valid_reg[match_idx] <= 1'b0;
                    end
                end
                REQ_FLUSH:  valid_reg <= '0;
                default:    ;
            endcase
            if (age_we) begin
                age_cnt_reg <= age_cnt_reg + AGE_W'(1);
            end
        end
    end

    // load the output register; drop it once the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (decide_go) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (decide_go) begin
            m_hit_reg   <= 1'b0;
            m_evict_reg <= 1'b0;
            m_virt_reg  <= '0;
            m_phys_reg  <= '0;
            m_plog_reg  <= '0;
            m_attrs_reg <= '0;
            unique case (req_type_reg)
                REQ_FILL: begin
                    m_hit_reg   <= 1'b1;
                    m_evict_reg <= !scan_stat.match_found && !scan_stat.free_found;
                    m_virt_reg  <= VA_PORT_W'(va_reg);
                    m_phys_reg  <= phys_reg;
                    m_plog_reg  <= plog_reg;
                    m_attrs_reg <= attrs_reg;
                end
                REQ_LOOKUP, REQ_INVAL: begin
                    if (scan_stat.match_found) begin
                        m_hit_reg   <= 1'b1;
                        m_virt_reg  <= VA_PORT_W'(hit_word[VA_W-1:0]);
                        m_phys_reg  <= hit_word[VA_W +: PHYS_W];
                        m_plog_reg  <= hit_word[VA_W+PHYS_W +: PLOG_W];
                        m_attrs_reg <= hit_word[VA_W+PHYS_W+PLOG_W +: ATTR_W];
                    end
                end
                REQ_FLUSH: ;
                default:   ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_attrs_reg, m_plog_reg, m_phys_reg, m_virt_reg};
    assign m_tuser  = {m_evict_reg, m_hit_reg};

    // ---------------- assertions ----------------
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (decide_go && req_type_reg == REQ_FLUSH) |=> (valid_reg == '0))
        else $error("flush left a valid entry");

    a_fill_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (decide_go && req_type_reg == REQ_FILL) |=> valid_reg[$past(tgt_idx)])
        else $error("filled entry not marked valid");

    a_age_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (age_cnt_reg == $past(age_cnt_reg)) ||
                           (age_cnt_reg == $past(age_cnt_reg) + AGE_W'(1)))
        else $error("age counter jumped");

    a_evict_implies_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_evict_reg) |-> m_hit_reg)
        else $error("eviction reported without hit");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_hit_reg) |-> (m_plog_reg == '0))
        else $error("miss result carries a page size");

endmodule

`default_nettype wire

// ----- bench/lru_translation_store_tb.sv -----
// ----------------------------------------------------------------------------
// lru_translation_store_tb: self-checking bench for the translation store
// Streams lookup, fill, invalidate and flush requests into the store, keeps
// a shadow table with its own LRU stamps, and checks every returned entry
// field by field. Runs through phases with no idling, sender gaps, result
// stalls and both at once, and lets the store drain between phases.
// ----------------------------------------------------------------------------

module lru_translation_store_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lts_pkg::*;

    localparam int SLOTS    = 16;
    localparam int VA_W     = 48;
    localparam int HOT_VAS  = 24;   // more hot pages than slots, so fills evict
    localparam int PER_PHASE = 310;
    localparam int BACKLOG_DEPTH = 2048;
    localparam int DUE_DEPTH     = 64;

    // one translation request as the sender sees it
    typedef struct packed {
        req_type_t          op;
        logic [VA_W-1:0]    va;
        logic               refresh;
        logic [PHYS_W-1:0]  pa;
        logic [PLOG_W-1:0]  plog;
        logic [ATTR_W-1:0]  attrs;
    } xlat_req_t;

    // one returned entry
    typedef struct packed {
        logic               hit;
        logic               evicted;
        logic [VA_W-1:0]    va;
        logic [PHYS_W-1:0]  pa;
        logic [PLOG_W-1:0]  plog;
        logic [ATTR_W-1:0]  attrs;
    } xlat_result_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [TDATA_W-1:0]         s_tdata;     // va[47:0] pa[99:48] plog[104:100] attrs[112:105]
    logic [IN_TUSER_W-1:0]      s_tuser;     // req_type[1:0] refresh_age[2]
    logic                       m_tvalid;
    logic                       m_tready;
    logic [TDATA_W-1:0]         m_tdata;     // va[47:0] pa[99:48] plog[104:100] attrs[112:105]
    logic [OUT_TUSER_W-1:0]     m_tuser;     // hit[0] evicted[1]

    // shadow copy of the translation table
    logic                       tbl_valid [SLOTS] = '{default: 1'b0};
    logic [VA_W-1:0]            tbl_virt  [SLOTS];
    logic [PHYS_W-1:0]          tbl_phys  [SLOTS];
    logic [PLOG_W-1:0]          tbl_plog  [SLOTS];
    logic [ATTR_W-1:0]          tbl_attr  [SLOTS];
    logic [AGE_W-1:0]           tbl_stamp [SLOTS];
    logic [AGE_W-1:0]           stamp_ctr = '0;

    // requests not yet offered: written by the sequence, read by the driver
    xlat_req_t                  req_backlog [BACKLOG_DEPTH];
    int                         backlog_wr = 0;
    int                         backlog_rd = 0;
    // entries the store still owes: written by the driver, read by the monitor
    xlat_result_t               due_results [DUE_DEPTH];
    int                         due_wr = 0;
    int                         due_rd = 0;
    xlat_req_t                  req_on_bus;
    xlat_result_t               got_result;
    xlat_result_t               want_result;
    logic [VA_W-1:0]            hot_va [HOT_VAS];
    int                         send_idle_pct;
    int                         stall_pct;
    int                         fail_count = 0;

    lru_translation_store #(
        .ENTRIES    (SLOTS),
        .VADDR_BITS (VA_W)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow table
    // ------------------------------------------------------------------------

    function automatic xlat_result_t view_entry(input int slot);
        xlat_result_t res;
        res.hit     = 1'b1;
        res.evicted = 1'b0;
        res.va      = tbl_virt[slot];
        res.pa      = tbl_phys[slot];
        res.plog    = tbl_plog[slot];
        res.attrs   = tbl_attr[slot];
        return res;
    endfunction

    // Apply one request to the shadow table and return the entry it yields.
    function automatic xlat_result_t translate_request(input xlat_req_t rq);
        xlat_result_t    res;
        int              slot;
        logic [VA_W-1:0] keep;
        logic [PLOG_W-1:0] plog;
        logic            evict;
        res   = '0;
        slot  = -1;
        evict = 1'b0;
        if (rq.op == REQ_FLUSH) begin
            // free everything, keep the stamp counter running
            for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
            return res;
        end
        // lowest matching slot wins; compare only bits at and above the page size
        for (int i = 0; i < SLOTS; i++) begin
            keep = {VA_W{1'b1}} << tbl_plog[i];
            if (slot < 0 && tbl_valid[i] && ((rq.va ^ tbl_virt[i]) & keep) == '0)
                slot = i;
        end
        case (rq.op)
            REQ_LOOKUP: begin
                if (slot >= 0) begin
                    if (rq.refresh) begin
                        tbl_stamp[slot] = stamp_ctr;
                        stamp_ctr++;
                    end
                    res = view_entry(slot);
                end
            end
            REQ_INVAL: begin
                if (slot >= 0) begin
                    res = view_entry(slot);
                    tbl_valid[slot] = 1'b0;
                end
            end
            default: begin
                // fill: clamp page size, then matching slot, lowest free, or oldest
                plog = rq.plog;
                if (plog < PL_MIN) plog = PL_MIN;
                if (plog > PL_MAX) plog = PL_MAX;
                if (slot < 0) begin
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!tbl_valid[i]) slot = i;
                end
                if (slot < 0) begin
                    slot  = 0;
                    evict = 1'b1;
                    for (int i = 1; i < SLOTS; i++)
                        if (tbl_stamp[i] < tbl_stamp[slot]) slot = i;
                end
                tbl_valid[slot] = 1'b1;
                tbl_virt[slot]  = rq.va;
                tbl_phys[slot]  = rq.pa;
                tbl_plog[slot]  = plog;
                tbl_attr[slot]  = rq.attrs;
                tbl_stamp[slot] = stamp_ctr;
                stamp_ctr++;
                res = view_entry(slot);
                res.evicted = evict;
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request stimulus
    // ------------------------------------------------------------------------

    task automatic queue_request(input req_type_t op, input logic [VA_W-1:0] va,
                                 input logic refresh, input logic [PHYS_W-1:0] pa,
                                 input logic [PLOG_W-1:0] plog,
                                 input logic [ATTR_W-1:0] attrs);
        xlat_req_t rq;
        rq.op      = op;
        rq.va      = va;
        rq.refresh = refresh;
        rq.pa      = pa;
        rq.plog    = plog;
        rq.attrs   = attrs;
        req_backlog[backlog_wr % BACKLOG_DEPTH] = rq;
        backlog_wr++;
    endtask

    // Mostly hot pages with random low bits so lookups hit at every page size;
    // now and then a fully random address and an out-of-range page size.
    task automatic queue_random_request();
        logic [63:0]     wide;
        logic [VA_W-1:0] low_mask;
        logic [VA_W-1:0] va;
        logic [PLOG_W-1:0] plog;
        int              pick;
        req_type_t       op;
        pick = $urandom_range(0, 99);
        if (pick < 45)      op = REQ_LOOKUP;
        else if (pick < 83) op = REQ_FILL;
        else if (pick < 99) op = REQ_INVAL;
        else                op = REQ_FLUSH;
        wide = {$urandom(), $urandom()};
        if ($urandom_range(0, 99) < 80) begin
            low_mask = ({{(VA_W-1){1'b0}}, 1'b1} << $urandom_range(0, 31)) - 1'b1;
            va = (hot_va[$urandom_range(0, HOT_VAS - 1)] & ~low_mask)
                 | (wide[VA_W-1:0] & low_mask);
        end else begin
            va = wide[VA_W-1:0];
        end
        if ($urandom_range(0, 99) < 80) plog = PLOG_W'($urandom_range(PL_MIN, PL_MAX));
        else                            plog = PLOG_W'($urandom_range(0, 31));
        wide = {$urandom(), $urandom()};
        queue_request(op, va, 1'($urandom_range(0, 1)), wide[PHYS_W-1:0], plog,
                      ATTR_W'($urandom_range(0, 255)));
    endtask

    // Block until nothing is queued, offered or owed. Sample on the falling
    // edge so the driver's and monitor's updates of this cycle are done.
    task automatic wait_drained();
        while (backlog_wr != backlog_rd || s_tvalid || due_wr != due_rd)
            @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer the next request whenever the slot is free
    // ------------------------------------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else begin
            // request taken at this edge: predict its result now
            if (s_tvalid && s_tready) begin
                due_results[due_wr % DUE_DEPTH] = translate_request(req_on_bus);
                due_wr++;
            end
            // hold while the store refuses, otherwise offer or go idle
            if (!s_tvalid || s_tready) begin
                if (backlog_wr != backlog_rd && $urandom_range(0, 99) >= send_idle_pct) begin
                    req_on_bus = req_backlog[backlog_rd % BACKLOG_DEPTH];
                    backlog_rd++;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'b0, req_on_bus.attrs, req_on_bus.plog,
                                 req_on_bus.pa, req_on_bus.va};
                    s_tuser  <= {req_on_bus.refresh, req_on_bus.op};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each returned entry against the oldest prediction
    // ------------------------------------------------------------------------

    task automatic compare_field(input string tag, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch: expected %h, actual %h", $time, tag, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_result.hit     = m_tuser[0];
                got_result.evicted = m_tuser[1];
                got_result.va      = m_tdata[47:0];
                got_result.pa      = m_tdata[99:48];
                got_result.plog    = m_tdata[104:100];
                got_result.attrs   = m_tdata[112:105];
                if (due_wr == due_rd) begin
                    $display("%0t ns: unexpected result: expected none, actual %h",
                             $time, got_result);
                    fail_count++;
                end else begin
                    want_result = due_results[due_rd % DUE_DEPTH];
                    due_rd++;
                    compare_field("hit", want_result.hit, got_result.hit);
                    compare_field("evicted", want_result.evicted, got_result.evicted);
                    compare_field("virt_addr", want_result.va, got_result.va);
                    compare_field("phys_addr", want_result.pa, got_result.pa);
                    compare_field("page_log", want_result.plog, got_result.plog);
                    compare_field("attrs", want_result.attrs, got_result.attrs);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed requests, then random phases
    // ------------------------------------------------------------------------

    initial begin
        logic [VA_W-1:0] page_x;
        logic [17:0]     region [3];
        aresetn       = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;

        // hot pages share three 1 GiB regions so large pages overlap small ones
        for (int i = 0; i < 3; i++) region[i] = 18'($urandom());
        for (int i = 0; i < HOT_VAS; i++) hot_va[i] = {region[i % 3], 30'($urandom())};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        page_x = 48'h1234_5678_9abc;
        // empty table: miss on lookup and invalidate, flush answers a miss
        queue_request(REQ_LOOKUP, '0, 1'b1, '0, '0, '0);
        queue_request(REQ_INVAL, '0, 1'b0, '0, '0, '0);
        queue_request(REQ_FLUSH, '1, 1'b1, '1, '1, '1);
        // address and data extremes; page size saturates high and low
        queue_request(REQ_FILL, '0, 1'b0, '0, PL_MIN, '0);
        queue_request(REQ_FILL, '1, 1'b1, '1, 5'd31, '1);
        queue_request(REQ_FILL, page_x, 1'b0, 52'h0_0000_1111_2222, 5'd0, 8'h5a);
        queue_request(REQ_LOOKUP, '1, 1'b1, '0, '0, '0);
        queue_request(REQ_LOOKUP, 48'h0fff, 1'b0, '0, '0, '0);
        // rewrite the matching 4 KiB entry in place
        queue_request(REQ_FILL, page_x ^ 48'h0ff, 1'b0, 52'hf_edcb_a987_6543, 5'd13, 8'ha5);
        // a 1 GiB page that also covers page_x: the lower slot wins the lookup
        queue_request(REQ_FILL, page_x ^ 48'h10_0000, 1'b0, 52'h1_2345_6789_abcd,
                      PL_MAX, 8'h3c);
        queue_request(REQ_LOOKUP, page_x, 1'b1, '0, '0, '0);
        queue_request(REQ_INVAL, page_x, 1'b0, '0, '0, '0);
        queue_request(REQ_LOOKUP, page_x, 1'b0, '0, '0, '0);

        // phases: no idling, sender gaps, result stalls, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 75; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 75; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase
            repeat (PER_PHASE) queue_random_request();
            // hold the sender until every owed result has come back
            wait_drained();
        end

        // drain: catch any stray result
        repeat (SLOTS + 3 + 16) @(posedge aclk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog: well beyond the slowest correct run
    initial begin
        #1_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
